/* hdl/rrba_pkg.sv */
`default_nettype none
package rrba_pkg;

  // default sizing
  localparam int unsigned BlockBytesDefault = 4096;
  localparam int unsigned FreeDepthDefault  = 1024;

  // field widths
  localparam int unsigned AddrW  = 48;
  localparam int unsigned SizeW  = 41;
  localparam int unsigned CountW = 42;
  localparam int unsigned SegW   = 2;
  localparam int unsigned NumSeg = 3;

  // configuration register indexes
  localparam logic [2:0] REG_SEG_COUNT = 3'd0;
  localparam logic [2:0] REG_SEG0_BASE = 3'd1;
  localparam logic [2:0] REG_SEG0_SIZE = 3'd2;
  localparam logic [2:0] REG_SEG1_BASE = 3'd3;
  localparam logic [2:0] REG_SEG1_SIZE = 3'd4;
  localparam logic [2:0] REG_SEG2_BASE = 3'd5;
  localparam logic [2:0] REG_SEG2_SIZE = 3'd6;

  // request opcodes
  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

endpackage
`default_nettype wire

/* hdl/round_robin_block_allocator.sv */
// a request accepted from the request stream moves to S_EXEC, and its result is written to the output
// register once that register is free; s_tready is high only in S_IDLE, so one request is in flight
// at a time; a finished result waits in the output register while the next request is accepted
// reset empties the free list, puts the bump pointers at the segment bases and reloads the
// available count in place; a write to registers 0 to 6 does the same via S_INIT, with s_tready low
`default_nettype none
module round_robin_block_allocator
  import rrba_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BlockBytesDefault,
  parameter int unsigned FREE_DEPTH  = FreeDepthDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration write port
  input  wire logic         cfg_wen,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_wdata,
  // request stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [55:0]  s_tdata,   // ret_segment[1:0], ret_addr[49:2], zero pad
  input  wire logic         s_tuser,   // opcode
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,   // block_segment[1:0], block_addr[49:2],
                                       // bytes_free[91:50], bytes_configured[133:92], zero pad
  output logic [1:0]        m_tuser    // status
);

  localparam int unsigned PtrW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FREE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FREE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FREE_DEPTH);
  localparam logic [AddrW:0] BlkExt = (AddrW + 1)'(BLOCK_BYTES);
  localparam logic [CountW-1:0] Blk = CountW'(BLOCK_BYTES);
  localparam logic [CountW-1:0] CntMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] RetLimit = CntMax - Blk;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  // configuration registers
  logic [1:0]       segment_count;
  logic [AddrW-1:0] seg_base [NumSeg];
  logic [SizeW-1:0] seg_size [NumSeg];

  // allocator state
  logic [1:0]        state;
  logic [PtrW-1:0]   fifo_head;
  logic [PtrW-1:0]   fifo_tail;
  logic [CntW-1:0]   fifo_count;
  logic [AddrW-1:0]  bump_pointer [NumSeg];
  logic [1:0]        current_segment;
  logic [CountW-1:0] avail_counter;

  // latched request
  logic              req_op;
  logic [1:0]        req_seg;
  logic [AddrW-1:0]  req_addr;

  // free-list memory
  logic [49:0] free_mem [FREE_DEPTH];
  logic [49:0] rd_data;
  logic        rd_en;
  logic        wr_en;

  // output register
  logic [1:0]        out_status;
  logic [1:0]        out_seg;
  logic [AddrW-1:0]  out_addr;
  logic [CountW-1:0] out_avail;
  logic [CountW-1:0] out_total;

  logic [1:0]        segs_in_use;
  logic [CountW:0]   total_sum;
  logic [CountW-1:0] total_now;
  logic [AddrW:0]    bump_end;
  logic [AddrW:0]    seg_limit;
  logic              fits;
  logic [1:0]        next_segment;
  logic              accept;
  logic              out_free;
  logic              finish;
  logic [CountW-1:0] avail_alloc;
  logic [CountW-1:0] avail_ret;

  // segment count and total size
  always_comb begin
    segs_in_use = (segment_count == 2'd0) ? 2'd1 : segment_count;
    total_sum = (CountW + 1)'(seg_size[0]);
    if (segs_in_use >= 2'd2) total_sum = total_sum + (CountW + 1)'(seg_size[1]);
    if (segs_in_use >= 2'd3) total_sum = total_sum + (CountW + 1)'(seg_size[2]);
    total_now = total_sum[CountW] ? CntMax : total_sum[CountW-1:0];
  end

  // bump fit check on the current segment, next segment and saturated available counts
  always_comb begin
    bump_end  = {1'b0, bump_pointer[current_segment]} + BlkExt;
    seg_limit = {1'b0, seg_base[current_segment]} + (AddrW + 1)'(seg_size[current_segment]);
    fits = (bump_end <= seg_limit) && !bump_end[AddrW];
    next_segment = (current_segment + 2'd1 >= segs_in_use) ? 2'd0
                                                          : current_segment + 2'd1;
    avail_alloc = (avail_counter < Blk) ? '0 : avail_counter - Blk;
    avail_ret = (avail_counter > RetLimit) ? CntMax : avail_counter + Blk;
  end

  // handshake control
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == S_EXEC) && out_free;
  assign rd_en    = accept;
  assign wr_en    = finish && (req_op == OP_RETURN) && (fifo_count != CntFull);

  // free-list memory, registered read of the head entry
  always_ff @(posedge clk) begin
    if (wr_en) free_mem[fifo_tail] <= {req_seg, req_addr};
    if (rd_en) rd_data <= free_mem[fifo_head];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= 2'd1;
      for (int i = 0; i < NumSeg; i++) begin
        seg_base[i] <= '0;
        seg_size[i] <= '0;
      end
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SEG_COUNT: segment_count <= cfg_wdata[1:0];
        REG_SEG0_BASE: seg_base[0] <= cfg_wdata;
        REG_SEG0_SIZE: seg_size[0] <= cfg_wdata[SizeW-1:0];
        REG_SEG1_BASE: seg_base[1] <= cfg_wdata;
        REG_SEG1_SIZE: seg_size[1] <= cfg_wdata[SizeW-1:0];
        REG_SEG2_BASE: seg_base[2] <= cfg_wdata;
        REG_SEG2_SIZE: seg_size[2] <= cfg_wdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // latched request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= s_tuser;
      req_seg  <= s_tdata[1:0];
      req_addr <= s_tdata[49:2];
    end
  end

  // sequencer and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      fifo_head       <= '0;
      fifo_tail       <= '0;
      fifo_count      <= '0;
      current_segment <= 2'd0;
      avail_counter   <= '0;
      for (int i = 0; i < NumSeg; i++) bump_pointer[i] <= '0;
    end else if (cfg_wen && cfg_index <= REG_SEG2_SIZE) begin
      // reload once the new register value is in place
      state <= S_INIT;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) state <= S_EXEC;
        end
        S_INIT: begin
          fifo_head       <= '0;
          fifo_tail       <= '0;
          fifo_count      <= '0;
          current_segment <= 2'd0;
          avail_counter   <= total_now;
          for (int i = 0; i < NumSeg; i++) bump_pointer[i] <= seg_base[i];
          state <= S_IDLE;
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
            if (req_op == OP_ALLOC) begin
              if (fifo_count != '0) begin
                // pop the oldest returned block
                fifo_head     <= (fifo_head == PtrLast) ? '0 : fifo_head + 1'b1;
                fifo_count    <= fifo_count - 1'b1;
                avail_counter <= avail_alloc;
              end else if (fits) begin
                // bump allocate and move to the next segment
                bump_pointer[current_segment] <= bump_end[AddrW-1:0];
                current_segment <= next_segment;
                avail_counter   <= avail_alloc;
              end
            end else if (fifo_count != CntFull) begin
              // push the returned block
              fifo_tail     <= (fifo_tail == PtrLast) ? '0 : fifo_tail + 1'b1;
              fifo_count    <= fifo_count + 1'b1;
              avail_counter <= avail_ret;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (finish) begin
      out_total  <= total_now;
      out_status <= ST_OK;
      out_seg    <= 2'd0;
      out_addr   <= '0;
      out_avail  <= avail_counter;
      if (req_op == OP_ALLOC) begin
        if (fifo_count != '0) begin
          out_seg   <= rd_data[49:48];
          out_addr  <= rd_data[AddrW-1:0];
          out_avail <= avail_alloc;
        end else if (fits) begin
          out_seg   <= current_segment;
          out_addr  <= bump_pointer[current_segment];
          out_avail <= avail_alloc;
        end else begin
          out_status <= ST_NO_SPACE;
        end
      end else if (fifo_count != CntFull) begin
        out_avail <= avail_ret;
      end else begin
        out_status <= ST_FULL;
      end
    end
  end

  assign m_tdata = {2'b00, out_total, out_avail, out_addr, out_seg};
  assign m_tuser = out_status;

endmodule
`default_nettype wire

/* hdl/rrba_checker.sv */
`default_nettype none
module rrba_checker
  import rrba_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata,
  input wire logic [1:0]   m_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // one request at a time: no accept in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // status is one of the defined codes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NO_SPACE || m_tuser == ST_FULL))
    else $error("undefined status code");

  // a refused request carries no block
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[49:0] == '0))
    else $error("refused request reports a block");

endmodule

bind round_robin_block_allocator rrba_checker u_rrba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

/* dv/round_robin_block_allocator_test.sv */
`timescale 1ns / 100ps
module round_robin_block_allocator_test;
  import rrba_pkg::*;

  localparam logic [41:0] CNT_MAX    = '1;
  localparam logic [41:0] BLOCK_SPAN = 42'(BlockBytesDefault);
  localparam logic [49:0] ADDR_TOP   = 50'h1_0000_0000_0000;
  localparam logic [47:0] ADDR_MAX   = '1;
  localparam logic [2:0]  REG_NONE   = 3'd7;  // no register behind this index
  localparam int unsigned LIST_DEPTH = FreeDepthDefault;

  typedef struct packed {
    logic        op;
    logic [1:0]  seg;
    logic [47:0] addr;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  seg;
    logic [47:0] addr;
    logic [41:0] avail;
    logic [41:0] total;
  } grant_t;

  typedef enum logic {STEP_CFG, STEP_REQ} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [2:0]  idx;
    logic [47:0] wdata;
    request_t    req;
    bit          typed;
    grant_t      res;
  } step_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_wen;
  logic [2:0]    cfg_index;
  logic [47:0]   cfg_wdata;
  logic          s_tvalid;
  logic          s_tready;
  logic [55:0]   s_tdata;   // ret_segment[1:0], ret_addr[49:2], zero pad
  logic          s_tuser;   // opcode
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [135:0]  m_tdata;   // block_segment[1:0], block_addr[49:2],
                            // bytes_free[91:50], bytes_configured[133:92], zero pad
  logic [1:0]    m_tuser;   // status

  round_robin_block_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator state as the testbench tracks it
  logic [1:0]  cfg_seg_count = 2'd1;
  logic [47:0] cfg_base [NumSeg];
  logic [40:0] cfg_size [NumSeg];
  logic [47:0] bump [NumSeg];
  int unsigned cur_seg;
  logic [41:0] avail_now;
  logic [49:0] free_blocks [$];

  grant_t      due_grants [$];
  logic [49:0] blocks_out [$];
  step_t       directed_steps [$];
  int unsigned mismatches;
  int unsigned grants_seen;
  int unsigned burst_left;

  function automatic void add_step(step_t s);
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic int unsigned seg_span();
    return (cfg_seg_count == 2'd0) ? 1 : int'(cfg_seg_count);
  endfunction

  function automatic logic [41:0] configured_bytes();
    logic [43:0] sum;
    sum = '0;
    for (int i = 0; i < seg_span(); i++) sum += 44'(cfg_size[i]);
    return (sum > 44'(CNT_MAX)) ? CNT_MAX : sum[41:0];
  endfunction

  function automatic void clear_allocator();
    free_blocks.delete();
    for (int i = 0; i < NumSeg; i++) bump[i] = cfg_base[i];
    cur_seg   = 0;
    avail_now = configured_bytes();
  endfunction

  // one request: pop the free list, else bump the current segment; or push a return
  function automatic grant_t allocate_or_return(request_t r);
    grant_t      g;
    logic [49:0] end_addr;
    logic [49:0] limit;
    bit          take;
    g    = '0;
    take = 1'b0;
    if (r.op == OP_ALLOC) begin
      if (free_blocks.size() > 0) begin
        {g.seg, g.addr} = free_blocks[0];
        free_blocks.delete(0);
        take = 1'b1;
      end else begin
        end_addr = {2'b0, bump[cur_seg]} + 50'(BLOCK_SPAN);
        limit    = {2'b0, cfg_base[cur_seg]} + 50'(cfg_size[cur_seg]);
        if (end_addr <= limit && end_addr < ADDR_TOP) begin
          g.seg         = 2'(cur_seg);
          g.addr        = bump[cur_seg];
          bump[cur_seg] = end_addr[47:0];
          cur_seg       = (cur_seg + 1 >= seg_span()) ? 0 : cur_seg + 1;
          take          = 1'b1;
        end else begin
          g.status = ST_NO_SPACE;
        end
      end
      if (take) avail_now = (avail_now < BLOCK_SPAN) ? '0 : avail_now - BLOCK_SPAN;
    end else if (free_blocks.size() >= LIST_DEPTH) begin
      g.status = ST_FULL;
    end else begin
      free_blocks.insert(free_blocks.size(), {r.seg, r.addr});
      avail_now = (avail_now > CNT_MAX - BLOCK_SPAN) ? CNT_MAX : avail_now + BLOCK_SPAN;
    end
    g.avail = avail_now;
    g.total = configured_bytes();
    return g;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r64;
    r64 = {$urandom(), $urandom()};
    return r64[47:0];
  endfunction

  function automatic logic [40:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 41'h100_0000_0000;
      default: return 41'(BlockBytesDefault * $urandom_range(0, 6)) +
                      (($urandom_range(0, 3) == 0) ? 41'($urandom_range(0, 4095)) : 41'd0);
    endcase
  endfunction

  function automatic logic [47:0] pick_base();
    logic [47:0] b;
    case ($urandom_range(0, 5))
      0:       b = '0;
      1:       b = 48'hFFFF_FFFF_F000 - 48'(BlockBytesDefault * $urandom_range(0, 4));
      2:       b = ADDR_MAX - 48'($urandom_range(0, 5 * BlockBytesDefault));
      default: begin
        b = rand48();
        if ($urandom_range(0, 1) == 1) b[11:0] = '0;
      end
    endcase
    return b;
  endfunction

  function automatic step_t cfg_step(logic [2:0] idx, logic [47:0] d);
    step_t s;
    s = '{kind: STEP_CFG, idx: idx, wdata: d, req: '0, typed: 1'b0, res: '0};
    return s;
  endfunction

  function automatic step_t req_step(logic op, logic [1:0] seg, logic [47:0] a);
    step_t s;
    s = '{kind: STEP_REQ, idx: '0, wdata: '0, req: '{op, seg, a}, typed: 1'b0, res: '0};
    return s;
  endfunction

  function automatic step_t chk_step(logic op, logic [1:0] seg, logic [47:0] a,
                                     logic [1:0] st, logic [1:0] bseg, logic [47:0] baddr,
                                     logic [41:0] av, logic [41:0] tot);
    step_t s;
    s = req_step(op, seg, a);
    s.typed = 1'b1;
    s.res   = '{st, bseg, baddr, av, tot};
    return s;
  endfunction

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // register write, only while nothing is in flight
  task automatic write_config(logic [2:0] idx, logic [47:0] d);
    case (idx)
      REG_SEG_COUNT: cfg_seg_count = d[1:0];
      REG_SEG0_BASE: cfg_base[0]   = d;
      REG_SEG0_SIZE: cfg_size[0]   = d[40:0];
      REG_SEG1_BASE: cfg_base[1]   = d;
      REG_SEG1_SIZE: cfg_size[1]   = d[40:0];
      REG_SEG2_BASE: cfg_base[2]   = d;
      REG_SEG2_SIZE: cfg_size[2]   = d[40:0];
      default: ;
    endcase
    if (idx != REG_NONE) clear_allocator();
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(negedge clk);
    cfg_wen   = 1'b0;
  endtask

  // drain every outstanding result before touching the registers
  task automatic settle();
    s_tvalid = 1'b0;
    while (due_grants.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // offer one request in bursts with random gaps, record the expected result on accept
  task automatic offer(request_t r, bit typed, grant_t typed_res);
    int unsigned gap;
    grant_t      g;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser  = r.op;
    s_tdata  = {6'b0, r.addr, r.seg};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = allocate_or_return(r);
    if (r.op == OP_ALLOC && g.status == ST_OK) begin
      blocks_out.insert(blocks_out.size(), {g.seg, g.addr});
    end
    due_grants.insert(due_grants.size(), typed ? typed_res : g);
    @(negedge clk);
  endtask

  // result side: compare each transaction with the oldest expectation
  grant_t head_grant;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      grants_seen++;
      if (due_grants.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, status %0d data 0x%0h", $time, m_tuser, m_tdata);
      end else begin
        head_grant = due_grants[0];
        due_grants.delete(0);
        check_field("status", 48'(head_grant.status), 48'(m_tuser));
        check_field("block_segment", 48'(head_grant.seg), 48'(m_tdata[1:0]));
        check_field("block_addr", head_grant.addr, m_tdata[49:2]);
        check_field("bytes_free", 48'(head_grant.avail), 48'(m_tdata[91:50]));
        check_field("bytes_configured", 48'(head_grant.total), 48'(m_tdata[133:92]));
      end
    end
  end

  // receiver stall pattern, with one long hold-off so the block backs up
  int unsigned rx_mode;
  int unsigned rx_left;
  int unsigned rx_tick;
  int unsigned hold_left;
  bit          long_hold_done;
  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else if (!long_hold_done && grants_seen >= 400) begin
      long_hold_done = 1'b1;
      hold_left      = 300;
      m_tready       = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_mode)
        0:       m_tready = 1'b1;
        1:       m_tready = ($urandom_range(0, 99) >= 35);
        default: m_tready = ((rx_tick % 5) < 3);
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned n_items;
    int unsigned p_alloc;
    int unsigned pick;
    logic [47:0] d;
    request_t    r;

    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_ALLOC;
    for (int i = 0; i < NumSeg; i++) begin
      cfg_base[i] = '0;
      cfg_size[i] = '0;
    end
    clear_allocator();

    // after reset: no space; returns and pops, including segment three and the top address
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_NO_SPACE, 2'd0, 48'd0, 0, 0));
    add_step(chk_step(OP_RETURN, 2'd3, ADDR_MAX, ST_OK, 2'd0, 48'd0,
                      42'h1000, 0));
    add_step(chk_step(OP_RETURN, 2'd0, 48'd0, ST_OK, 2'd0, 48'd0, 42'h2000, 0));
    add_step(cfg_step(REG_NONE, ADDR_MAX));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd3, ADDR_MAX,
                      42'h1000, 0));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd0, 48'd0, 0, 0));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_NO_SPACE, 2'd0, 48'd0, 0, 0));
    // three segments: round robin, exact fit, refusal at the top of the address space
    add_step(cfg_step(REG_SEG_COUNT, 48'd3));
    add_step(cfg_step(REG_SEG0_BASE, 48'd0));
    add_step(cfg_step(REG_SEG0_SIZE, 48'h2000));
    add_step(cfg_step(REG_SEG1_BASE, 48'hFFFF_FFFF_E000));
    add_step(cfg_step(REG_SEG1_SIZE, 48'h100_0000_0000));
    add_step(cfg_step(REG_SEG2_BASE, 48'h0000_1234_5000));
    add_step(cfg_step(REG_SEG2_SIZE, 48'h1000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd0, 48'd0,
                      42'h100_0000_2000, 42'h100_0000_3000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd1, 48'hFFFF_FFFF_E000,
                      42'h100_0000_1000, 42'h100_0000_3000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd2, 48'h0000_1234_5000,
                      42'h100_0000_0000, 42'h100_0000_3000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd0, 48'h1000,
                      42'h0FF_FFFF_F000, 42'h100_0000_3000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_NO_SPACE, 2'd0, 48'd0,
                      42'h0FF_FFFF_F000, 42'h100_0000_3000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_NO_SPACE, 2'd0, 48'd0,
                      42'h0FF_FFFF_F000, 42'h100_0000_3000));
    add_step(chk_step(OP_RETURN, 2'd2, 48'hABC, ST_OK, 2'd0, 48'd0,
                      42'h100_0000_0000, 42'h100_0000_3000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd2, 48'hABC,
                      42'h0FF_FFFF_F000, 42'h100_0000_3000));
    // segment count zero behaves as one; upper data bits are dropped
    add_step(cfg_step(REG_SEG_COUNT, 48'hFFFF_FFFF_FFFC));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd0, 48'd0,
                      42'h1000, 42'h2000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd0, 48'h1000,
                      0, 42'h2000));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_NO_SPACE, 2'd0, 48'd0,
                      0, 42'h2000));
    // widest sizes: total and available count saturate
    add_step(cfg_step(REG_SEG0_SIZE, ADDR_MAX));
    add_step(cfg_step(REG_SEG1_SIZE, ADDR_MAX));
    add_step(cfg_step(REG_SEG2_SIZE, ADDR_MAX));
    add_step(cfg_step(REG_SEG_COUNT, 48'd3));
    add_step(chk_step(OP_RETURN, 2'd1, 48'h5000, ST_OK, 2'd0, 48'd0,
                      CNT_MAX, CNT_MAX));
    add_step(chk_step(OP_ALLOC, 2'd0, 48'd0, ST_OK, 2'd1, 48'h5000,
                      CNT_MAX - BLOCK_SPAN, CNT_MAX));
    add_step(req_step(OP_ALLOC, 2'd0, 48'd0));
    add_step(req_step(OP_ALLOC, 2'd0, 48'd0));
    add_step(req_step(OP_ALLOC, 2'd0, 48'd0));
    add_step(req_step(OP_RETURN, 2'd0, 48'd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        settle();
        write_config(directed_steps[i].idx, directed_steps[i].wdata);
      end else begin
        offer(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].res);
      end
    end

    // random phases, each with fresh segments; phase three floods the free list
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      d      = rand48();
      d[1:0] = (ph == 0) ? 2'd3 : (ph == 1) ? 2'd1 : (ph == 3) ? 2'd2
                                                  : 2'($urandom_range(0, 3));
      write_config(REG_SEG_COUNT, d);
      for (int s = 0; s < NumSeg; s++) begin
        write_config(3'(REG_SEG0_BASE + 2 * s), pick_base());
        d       = rand48();
        d[40:0] = pick_size();
        if ($urandom_range(0, 1) == 0) d[47:41] = '0;
        write_config(3'(REG_SEG0_SIZE + 2 * s), d);
      end
      if ($urandom_range(0, 3) == 0) write_config(REG_NONE, rand48());

      n_items = (ph == 3) ? 1100 : 119;
      p_alloc = (ph == 3) ? 2 : $urandom_range(35, 75);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < p_alloc) begin
          r = '{OP_ALLOC, 2'($urandom_range(0, 3)), rand48()};
        end else if (blocks_out.size() > 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, blocks_out.size() - 1);
          r    = '{OP_RETURN, blocks_out[pick][49:48], blocks_out[pick][47:0]};
          blocks_out.delete(pick);
        end else begin
          r = '{OP_RETURN, 2'($urandom_range(0, 3)), rand48()};
        end
        offer(r, 1'b0, '0);
      end
    end

    // wind down: everything answered, then quiet before the verdict
    s_tvalid = 1'b0;
    while (due_grants.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && due_grants.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* round_robin_block_allocator.f */
hdl/rrba_pkg.sv
hdl/round_robin_block_allocator.sv
hdl/rrba_checker.sv
dv/round_robin_block_allocator_test.sv
